>>> src/deq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue.
`default_nettype none

package deq_pkg;

	// Geometry of the ring buffer.
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	// Field widths on the stream ports.
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int ECOUNT_W = 5;
	localparam int IN_W = 40;
	localparam int OUT_W = 72;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// Memory access request issued when an item is accepted.
	typedef struct packed {
		logic re;
		logic we;
		logic [IDX_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0] raddr0;
		logic [IDX_W-1:0] raddr1;
	} mem_req_t;

	// Outcome of one item, held until the next item is accepted.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0] count;
	} op_res_t;

	// Ring index step forward with wrap.
	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		wrap_inc = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	// Ring index step backward with wrap.
	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
		wrap_dec = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
	endfunction

endpackage

`default_nettype wire

>>> src/double_ended_queue.sv
// On accept, the control state is registered and the slot memory read
// fetches the new front and back elements; the result is then loaded into
// the output register. No new item is taken until that load.
// A result that is not taken holds the block after the read returns.
// Reset empties the queue; slot contents are not cleared, and data from a
// slot not yet written never reaches the output.
`default_nettype none

module double_ended_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// tdata: action [2:0], value [34:3], zero fill [39:35]
	input wire logic [deq_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// tdata: status [1:0], front_value [33:2], back_value [65:34],
	// element_count [70:66], is_empty [71]
	output logic [deq_pkg::OUT_W-1:0] m_tdata
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;
	logic accept, load;
	deq_pkg::mem_req_t req;
	deq_pkg::op_res_t res;
	logic [deq_pkg::DATA_W-1:0] rdata0, rdata1;
	logic hit0_q, hit1_q;
	logic [deq_pkg::DATA_W-1:0] fwd_q;
	logic [deq_pkg::DATA_W-1:0] front_val, back_val;
	logic empty;
	logic m_tvalid_q;
	logic [deq_pkg::OUT_W-1:0] m_tdata_q;

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign load = (state_q == S_READ) && (!m_tvalid_q || m_tready);

	deq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.action(s_tdata[2:0]),
		.value(s_tdata[34:3]),
		.req(req),
		.res(res)
	);

	deq_ram #(
		.DEPTH_P(deq_pkg::DEPTH),
		.WIDTH_P(deq_pkg::DATA_W)
	) u_ram (
		.clk(clk),
		.re(req.re),
		.raddr0(req.raddr0),
		.raddr1(req.raddr1),
		.rdata0(rdata0),
		.rdata1(rdata1),
		.we(req.we),
		.waddr(req.waddr),
		.wdata(req.wdata)
	);

	// Forwarding of a write that lands on a slot read in the same cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit0_q <= req.we && (req.waddr == req.raddr0);
			hit1_q <= req.we && (req.waddr == req.raddr1);
			fwd_q <= req.wdata;
		end
	end

	assign empty = (res.count == '0);
	assign front_val = empty ? '0 : (hit0_q ? fwd_q : rdata0);
	assign back_val = empty ? '0 : (hit1_q ? fwd_q : rdata1);

	// Sequencer: accept, then wait for the read data and an output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {empty, deq_pkg::ECOUNT_W'(res.count), back_val, front_val,
				res.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire

>>> src/deq_ram.sv
// Generic RAM with one write port and two registered read ports, read-first.
`default_nettype none

module deq_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32
) (
	input wire logic clk,
	input wire logic re,
	input wire logic [$clog2(DEPTH_P)-1:0] raddr0,
	input wire logic [$clog2(DEPTH_P)-1:0] raddr1,
	output logic [WIDTH_P-1:0] rdata0,
	output logic [WIDTH_P-1:0] rdata1,
	input wire logic we,
	input wire logic [$clog2(DEPTH_P)-1:0] waddr,
	input wire logic [WIDTH_P-1:0] wdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

`default_nettype wire

>>> src/deq_ctrl.sv
// Front and back pointers, element count and memory request generation.
`default_nettype none

module deq_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [deq_pkg::ACTION_W-1:0] action,
	input wire logic [deq_pkg::DATA_W-1:0] value,
	output deq_pkg::mem_req_t req,
	output deq_pkg::op_res_t res
);

	logic [deq_pkg::IDX_W-1:0] front_q, back_q;
	logic [deq_pkg::CNT_W-1:0] count_q;
	logic [deq_pkg::STATUS_W-1:0] status_q;
	logic [deq_pkg::IDX_W-1:0] front_d, back_d;
	logic [deq_pkg::CNT_W-1:0] count_d;
	logic [deq_pkg::STATUS_W-1:0] status_d;
	logic wr_en;
	logic [deq_pkg::IDX_W-1:0] wr_addr;
	logic is_full, is_zero;

	assign is_full = (count_q >= deq_pkg::CNT_W'(deq_pkg::DEPTH));
	assign is_zero = (count_q == '0);

	// Next pointers, count and the slot to write for this item.
	always_comb begin
		front_d = front_q;
		back_d = back_q;
		count_d = count_q;
		status_d = deq_pkg::ST_DONE;
		wr_en = 1'b0;
		wr_addr = front_q;
		case (action)
			deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
				if (is_full) begin
					status_d = deq_pkg::ST_FULL;
				end else if (is_zero) begin
					wr_en = 1'b1;
					wr_addr = front_q;
					back_d = front_q;
					count_d = deq_pkg::CNT_W'(1);
				end else if (action == deq_pkg::ACT_PUSH_FRONT) begin
					front_d = deq_pkg::wrap_dec(front_q);
					wr_en = 1'b1;
					wr_addr = front_d;
					count_d = count_q + deq_pkg::CNT_W'(1);
				end else begin
					back_d = deq_pkg::wrap_inc(back_q);
					wr_en = 1'b1;
					wr_addr = back_d;
					count_d = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
				if (is_zero) begin
					status_d = deq_pkg::ST_EMPTY;
				end else if (count_q == deq_pkg::CNT_W'(1)) begin
					back_d = front_q;
					count_d = '0;
				end else begin
					if (action == deq_pkg::ACT_POP_FRONT) begin
						front_d = deq_pkg::wrap_inc(front_q);
					end else begin
						back_d = deq_pkg::wrap_dec(back_q);
					end
					count_d = count_q - deq_pkg::CNT_W'(1);
				end
			end
			default: begin
				// Query and unused codes leave the state alone.
				status_d = deq_pkg::ST_DONE;
			end
		endcase
	end

	// Memory request: write the pushed value, read the new ends.
	always_comb begin
		req.re = accept;
		req.we = accept && wr_en;
		req.waddr = wr_addr;
		req.wdata = value;
		req.raddr0 = front_d;
		req.raddr1 = back_d;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q <= '0;
			count_q <= '0;
			status_q <= deq_pkg::ST_DONE;
		end else if (accept) begin
			front_q <= front_d;
			back_q <= back_d;
			count_q <= count_d;
			status_q <= status_d;
		end
	end

	assign res.status = status_q;
	assign res.count = count_q;

endmodule

`default_nettype wire
